// ===== design/htbd_pkg.sv =====
// ----------------------------------------------------------------------------
// htbd_pkg
// shared types and constants for the huffman tree bit decoder
// ----------------------------------------------------------------------------
package htbd_pkg;

    localparam int NODE_W         = 7;
    localparam int SYM_W          = 8;
    localparam int BYTE_W         = 8;
    localparam int TREE_NODES_DEF = 128;

    typedef enum logic
    {
        OP_DECODE = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    // one stored tree node
    typedef struct packed
    {
        logic              leaf;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [SYM_W-1:0]  sym;
    } node_t;

    typedef struct packed
    {
        op_t               opcode;
        logic [BYTE_W-1:0] data_byte;
        logic [NODE_W-1:0] node_index;
        logic              node_is_leaf;
        logic [NODE_W-1:0] left_child;
        logic [NODE_W-1:0] right_child;
        logic [SYM_W-1:0]  leaf_symbol;
    } in_item_t;

    typedef struct packed
    {
        logic [SYM_W-1:0] symbol;
        logic             last_of_byte;
    } out_item_t;

endpackage

// ===== design/htbd_node_ram.sv =====
// ----------------------------------------------------------------------------
// htbd_node_ram
// node table: one write and one registered read port, out of range reads zero
// ----------------------------------------------------------------------------
module htbd_node_ram
#(
    parameter int TREE_NODES = htbd_pkg::TREE_NODES_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [htbd_pkg::NODE_W-1:0]   waddr,
    input  htbd_pkg::node_t               wdata,
    input  logic                          re,
    input  logic [htbd_pkg::NODE_W-1:0]   raddr,
    output htbd_pkg::node_t               rdata
);
    import htbd_pkg::*;

    localparam int AW = $clog2(TREE_NODES);

    node_t mem [TREE_NODES];
    node_t rd_reg;
    logic  rd_ok_reg;
    logic  w_ok;
    logic  r_ok;

    assign w_ok = (32'(waddr) < 32'(TREE_NODES));
    assign r_ok = (32'(raddr) < 32'(TREE_NODES));

    always_ff @(posedge clk)
    begin
        if (we && w_ok)
        begin
            mem[AW'(waddr)] <= wdata;
        end
    end

    // indices past the table read as an all zero branch
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_ok_reg <= r_ok;
            if (r_ok)
            begin
                rd_reg <= mem[AW'(raddr)];
            end
        end
    end

    assign rdata = rd_ok_reg ? rd_reg : '0;

endmodule

// ===== design/huffman_tree_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// decodes packed code bits by walking a code tree held in a node memory
// ----------------------------------------------------------------------------
// write transaction: busy stays low, no result
// decode transaction: root read on acceptance; busy for the walk node read, one
//   dependent node memory read per bit and a flush state; a new one is taken
//   once busy drops; results strobe from the walk, the last from the flush state
// results cannot be stalled: each strobe lasts exactly one cycle
// reset clears control, root and walk position to node 0; table undefined
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder
#(
    parameter int TREE_NODES = htbd_pkg::TREE_NODES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  htbd_pkg::in_item_t          item,
    input  logic                        cfg_we,
    input  logic [htbd_pkg::NODE_W-1:0] cfg_wdata,
    output logic                        result_strobe,
    output htbd_pkg::out_item_t         result
);
    import htbd_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_ROOT  = 5'b00010,
        ST_FIRST = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t              state_reg,  state_next;
    logic [NODE_W-1:0]   root_reg,   root_next;
    logic [NODE_W-1:0]   walk_reg,   walk_next;
    logic [NODE_W-1:0]   pos_reg,    pos_next;
    logic [2:0]          bit_reg,    bit_next;
    logic [BYTE_W-1:0]   byte_reg,   byte_next;
    node_t               rootn_reg,  rootn_next;
    logic                pend_reg,   pend_next;
    logic [SYM_W-1:0]    psym_reg,   psym_next;
    logic                strobe_reg, strobe_next;
    out_item_t           res_reg,    res_next;

    // node memory port signals
    logic                accept;
    logic                mem_we;
    node_t               mem_wdata;
    logic                mem_re;
    logic [NODE_W-1:0]   mem_raddr;
    node_t               mem_rdata;

    // walk step signals
    logic                hit_leaf;
    node_t               cur_node;
    logic [NODE_W-1:0]   child;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // tree node writes go straight into the memory on acceptance
    assign mem_we    = accept && (item.opcode == OP_WRITE);
    assign mem_wdata = '{leaf:  item.node_is_leaf,
                         left:  item.left_child,
                         right: item.right_child,
                         sym:   item.leaf_symbol};

    htbd_node_ram #(
        .TREE_NODES (TREE_NODES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (item.node_index),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // in the walk, read data is the node just reached; a leaf sends the
    // next step from the root node held in a register
    assign hit_leaf = mem_rdata.leaf;
    assign cur_node = (hit_leaf && (state_reg == ST_WALK)) ? rootn_reg : mem_rdata;

    always_comb
    begin
        state_next  = state_reg;
        root_next   = root_reg;
        walk_next   = walk_reg;
        pos_next    = pos_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        rootn_next  = rootn_reg;
        pend_next   = pend_reg;
        psym_next   = psym_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        mem_re      = 1'b0;
        mem_raddr   = walk_reg;
        child       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // root register write restarts the walk
                if (cfg_we)
                begin
                    root_next = cfg_wdata;
                    walk_next = cfg_wdata;
                end
                if (accept && (item.opcode == OP_DECODE))
                begin
                    byte_next  = item.data_byte;
                    bit_next   = 3'd7;
                    pend_next  = 1'b0;
                    mem_re     = 1'b1;
                    mem_raddr  = root_reg;
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                rootn_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = walk_reg;
                state_next = ST_FIRST;
            end

            ST_FIRST:
            begin
                // step on the top bit from the current walk node
                child      = byte_reg[bit_reg] ? cur_node.right : cur_node.left;
                mem_re     = 1'b1;
                mem_raddr  = child;
                pos_next   = child;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                if (hit_leaf)
                begin
                    // hold back one symbol so the last one of the byte is known
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next    = '{symbol: psym_reg, last_of_byte: 1'b0};
                    end
                    pend_next = 1'b1;
                    psym_next = mem_rdata.sym;
                    walk_next = root_reg;
                end
                else
                begin
                    walk_next = pos_reg;
                end

                if (bit_reg == 3'd0)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    child      = byte_reg[bit_reg - 3'd1] ? cur_node.right : cur_node.left;
                    mem_re     = 1'b1;
                    mem_raddr  = child;
                    pos_next   = child;
                    bit_next   = bit_reg - 3'd1;
                end
            end

            ST_FLUSH:
            begin
                if (pend_reg)
                begin
                    strobe_next = 1'b1;
                    res_next    = '{symbol: psym_reg, last_of_byte: 1'b1};
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            root_reg   <= '0;
            walk_reg   <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            root_reg   <= root_next;
            walk_reg   <= walk_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        bit_reg   <= bit_next;
        byte_reg  <= byte_next;
        rootn_reg <= rootn_next;
        psym_reg  <= psym_next;
        res_reg   <= res_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

// ===== tb/sv/tb_huffman_tree_bit_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_bit_decoder
// self-checking bench: loads a small working region of the node table, runs
// directed prefix-code cases and random traffic under several root settings,
// and compares every strobed symbol with a shadow tree walk kept in the bench
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder;

    import htbd_pkg::*;

    localparam int TREE_SIZE      = TREE_NODES_DEF;
    localparam int TREE_USED      = 16;    // nodes loaded and reachable by every walk
    localparam int RANDOM_ITEMS   = 24;    // per root setting
    localparam int SETTLE_CYCLES  = 16;    // a little over one decode
    localparam int WATCHDOG_LIMIT = 400;   // cycles with no transaction at all
    localparam int MAX_REPORTS    = 10;
    localparam int GAP_PERCENT    = 28;
    localparam int LEAF_PERCENT   = 40;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_item_t            item;
    logic                cfg_we;
    logic [NODE_W-1:0]   cfg_wdata;
    logic                result_strobe;
    out_item_t           result;

    // shadow copy of the block state
    node_t               shadow_tree [TREE_SIZE];
    logic [NODE_W-1:0]   tree_root;
    logic [NODE_W-1:0]   walk_node;

    // symbols still owed by the block, oldest first
    out_item_t           expected_symbols [$];

    int                  mismatch_count;
    int                  idle_cycles;
    bit                  gaps_on;

    huffman_tree_bit_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow tree walk: one step per code bit, msb first; only the node
    // reached by a step is tested for being a leaf
    // ------------------------------------------------------------------------
    function automatic void walk_byte(input logic [BYTE_W-1:0] code_bits);
        node_t             here;
        node_t             reached;
        logic [NODE_W-1:0] next_idx;
        out_item_t         batch [$];
        out_item_t         sym_out;
        for (int b = BYTE_W - 1; b >= 0; b--)
        begin
            here     = shadow_tree[walk_node];
            next_idx = code_bits[b] ? here.right : here.left;
            reached  = shadow_tree[next_idx];
            if (reached.leaf)
            begin
                sym_out.symbol       = reached.sym;
                sym_out.last_of_byte = 1'b0;
                batch                = {batch, sym_out};
                walk_node            = tree_root;
            end
            else
            begin
                walk_node = next_idx;
            end
        end
        // only the final symbol of the byte carries the flag
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_byte = 1'b1;
        foreach (batch[i])
            expected_symbols = {expected_symbols, batch[i]};
    endfunction

    // update the shadow state for one accepted transaction
    function automatic void apply_item(input in_item_t it);
        if (it.opcode == OP_WRITE)
            shadow_tree[it.node_index] = {it.node_is_leaf, it.left_child,
                                          it.right_child, it.leaf_symbol};
        else
            walk_byte(it.data_byte);
    endfunction

    // node write; the unused byte field is filled at random
    function automatic in_item_t node_write(input logic [NODE_W-1:0] idx,
                                            input logic              is_leaf,
                                            input logic [NODE_W-1:0] left,
                                            input logic [NODE_W-1:0] right,
                                            input logic [SYM_W-1:0]  sym);
        in_item_t it;
        it.opcode       = OP_WRITE;
        it.data_byte    = BYTE_W'($urandom_range(0, 255));
        it.node_index   = idx;
        it.node_is_leaf = is_leaf;
        it.left_child   = left;
        it.right_child  = right;
        it.leaf_symbol  = sym;
        return it;
    endfunction

    // decode of one byte; the node fields are ignored, so they are random
    function automatic in_item_t byte_decode(input logic [BYTE_W-1:0] code_bits);
        in_item_t it;
        it           = in_item_t'({$urandom, $urandom});
        it.opcode    = OP_DECODE;
        it.data_byte = code_bits;
        return it;
    endfunction

    // children stay inside the loaded region
    function automatic in_item_t random_node_write(input logic [NODE_W-1:0] idx);
        return node_write(idx, $urandom_range(0, 99) < LEAF_PERCENT,
                          NODE_W'($urandom_range(0, TREE_USED - 1)),
                          NODE_W'($urandom_range(0, TREE_USED - 1)),
                          SYM_W'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // sender: start stays high after a transaction so that a back-to-back
    // item needs no lowering; it is only dropped for a gap or a drain
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        while (gaps_on && ($urandom_range(0, 99) < GAP_PERCENT))
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_item(it);
    endtask

    // wait for all owed symbols, then let a silent decode run out
    task automatic drain_decoder();
        start <= 1'b0;
        while (expected_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // root write, only while the decoder is idle; restarts the walk
    task automatic set_root(input logic [NODE_W-1:0] new_root);
        cfg_we    <= 1'b1;
        cfg_wdata <= new_root;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tree_root = new_root;
        walk_node = new_root;
    endtask

    // ------------------------------------------------------------------------
    // result checker: the receiver cannot stall, every strobe is a transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_symbols.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: symbol %02h last %0b",
                             result.symbol, result.last_of_byte);
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (result.symbol !== want.symbol
                    || result.last_of_byte !== want.last_of_byte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected symbol %02h last %0b, got %02h last %0b",
                                 want.symbol, want.last_of_byte,
                                 result.symbol, result.last_of_byte);
                end
            end
        end
    end

    // watchdog: counts cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every node of the working region written before any decode, and all
    // children point back into it, so no walk reads an unset entry
    task automatic test_table_load();
        set_root(7'd0);
        for (int n = 0; n < TREE_USED; n++)
            send_item(random_node_write(NODE_W'(n)));
        drain_decoder();
    endtask

    // small prefix code at node 0: A=0, B=10, 00=110, ff=111
    task automatic test_prefix_codes();
        send_item(node_write(7'd0, 1'b0, 7'd1, 7'd2, 8'h00));
        send_item(node_write(7'd1, 1'b1, 7'd0, 7'd0, 8'h41));
        send_item(node_write(7'd2, 1'b0, 7'd3, 7'd4, 8'h00));
        send_item(node_write(7'd3, 1'b1, 7'd0, 7'd0, 8'h42));
        send_item(node_write(7'd4, 1'b0, 7'd5, 7'd6, 8'h00));
        send_item(node_write(7'd5, 1'b1, 7'd0, 7'd0, 8'h00));
        send_item(node_write(7'd6, 1'b1, 7'd15, 7'd15, 8'hff));
        drain_decoder();
        set_root(7'd0);
        send_item(byte_decode(8'h00));  // eight symbols from one byte
        send_item(byte_decode(8'hff));  // two symbols, walk left part-way
        send_item(byte_decode(8'h7f));  // code spanning the byte boundary
        send_item(byte_decode(8'h96));  // mixed code lengths
        drain_decoder();
    endtask

    // the node under the walk position is rewritten as a leaf mid-code
    task automatic test_leaf_rewrite();
        set_root(7'd0);
        send_item(byte_decode(8'hff));  // walk ends on node 4
        send_item(node_write(7'd4, 1'b1, 7'd5, 7'd6, 8'h77));
        send_item(byte_decode(8'h00));  // leaf still steers by its children
        send_item(byte_decode(8'hc3));  // node 4 now reached as a leaf
        drain_decoder();
    endtask

    // root on a branch that loops to itself: a byte gives no symbol
    task automatic test_silent_root();
        send_item(node_write(7'd8, 1'b0, 7'd8, 7'd8, 8'h00));
        drain_decoder();
        set_root(7'd8);
        send_item(byte_decode(8'ha5));
        drain_decoder();
    endtask

    // root itself a leaf: every bit reaches a leaf child
    task automatic test_leaf_root();
        send_item(node_write(7'd9, 1'b1, 7'd1, 7'd3, 8'h5a));
        drain_decoder();
        set_root(7'd9);
        send_item(byte_decode(8'h5a));
        drain_decoder();
    endtask

    // random mix of decodes and node writes under several root settings,
    // one phase with no sender gaps at all
    task automatic test_random_traffic();
        logic [NODE_W-1:0] roots [4];
        roots[0] = NODE_W'(TREE_USED - 1);
        roots[1] = NODE_W'($urandom_range(0, TREE_USED - 1));
        roots[2] = 7'd0;
        roots[3] = NODE_W'($urandom_range(0, TREE_USED - 1));
        for (int p = 0; p < 4; p++)
        begin
            drain_decoder();
            set_root(roots[p]);
            gaps_on = (p != 2);
            for (int k = 0; k < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_item(random_node_write(NODE_W'($urandom_range(0, TREE_USED - 1))));
                else
                    send_item(byte_decode(BYTE_W'($urandom_range(0, 255))));
            end
        end
        gaps_on = 1'b1;
        drain_decoder();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
        tree_root      = '0;
        walk_node      = '0;
        foreach (shadow_tree[i])
            shadow_tree[i] = '0;

        // single reset at the start of the run
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_prefix_codes();
        test_leaf_rewrite();
        test_silent_root();
        test_leaf_root();
        test_random_traffic();

        // drain_decoder above already waited out the last decode
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
